@@ design/rhd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhd_pkg;

  // NAL unit types handled specially
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A   = 5'd28;

  // Packet error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Fixed RTP header length less the first byte
  localparam logic [17:0] HDR_REST = 18'd11;

  // Index of the final start-code byte (00 00 00 01)
  localparam logic [2:0] START_LAST = 3'd3;
  // Index of the main result behind a start code
  localparam logic [2:0] MAIN_IDX   = 3'd4;

  // Results caused by one packet byte: optional start code, then one result
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       valid;
    logic       nal_end;
    logic [1:0] err;
  } step_res_t;

endpackage

`default_nettype wire

@@ design/rhd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhd_parser (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [7:0]             in_byte,
  input  wire                    in_last,
  output logic                   res_valid,
  output rhd_pkg::step_res_t     res,
  input  wire                    res_take
);
  import rhd_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR, PH_EXT, PH_NALHDR, PH_SINGLE, PH_SIZE_HI, PH_SIZE_LO,
    PH_UNIT_FST, PH_UNIT_MORE, PH_FU_HDR, PH_FU_DATA, PH_DROP
  } phase_t;

  phase_t      phase, phase_next;
  logic [17:0] hdr_left, hdr_left_next;     // header bytes still to skip
  logic [1:0]  ext_cnt, ext_cnt_next;       // byte index in extension header
  logic        ext_flag, ext_flag_next;
  logic [7:0]  ext_high, ext_high_next;
  logic [15:0] unit_rem, unit_rem_next;
  logic [2:0]  fu_ind, fu_ind_next;
  logic        fu_active, fu_active_next;
  logic        fu_end, fu_end_next;

  logic        emit;
  step_res_t   r;
  logic [15:0] words;
  logic [15:0] rem_dec;
  logic        accept;

  assign in_ready = !res_valid || res_take;
  assign accept   = in_valid && in_ready;
  assign words    = {ext_high, in_byte};
  assign rem_dec  = unit_rem - 16'd1;

  // Next state and results for the byte at the input
  always_comb begin
    phase_next     = phase;
    hdr_left_next  = hdr_left;
    ext_cnt_next   = ext_cnt;
    ext_flag_next  = ext_flag;
    ext_high_next  = ext_high;
    unit_rem_next  = unit_rem;
    fu_ind_next    = fu_ind;
    fu_active_next = fu_active;
    fu_end_next    = fu_end;
    emit           = 1'b0;
    r              = '0;

    unique case (phase)
      PH_HDR0: begin
        hdr_left_next = HDR_REST + {12'd0, in_byte[3:0], 2'b00};
        ext_flag_next = in_byte[4];
        phase_next    = PH_HDR;
      end
      PH_HDR: begin
        hdr_left_next = hdr_left - 18'd1;
        if (hdr_left == 18'd1) begin
          if (ext_flag) begin
            ext_cnt_next = 2'd0;
            phase_next   = PH_EXT;
          end else begin
            phase_next = PH_NALHDR;
          end
        end
      end
      PH_EXT: begin
        ext_cnt_next = ext_cnt + 2'd1;
        if (ext_cnt == 2'd2) begin
          ext_high_next = in_byte;
        end else if (ext_cnt == 2'd3) begin
          hdr_left_next = {words, 2'b00};
          ext_flag_next = 1'b0;
          phase_next    = (words != 16'd0) ? PH_HDR : PH_NALHDR;
        end
      end
      PH_NALHDR: begin
        if (in_byte[4:0] == NAL_STAP_A) begin
          fu_active_next = 1'b0;
          phase_next     = PH_SIZE_HI;
        end else if (in_byte[4:0] == NAL_FU_A) begin
          fu_ind_next = in_byte[7:5];
          phase_next  = PH_FU_HDR;
        end else begin
          fu_active_next = 1'b0;
          emit           = 1'b1;
          r              = '{start: 1'b1, data: in_byte, valid: 1'b1,
                             nal_end: in_last, err: ERR_NONE};
          phase_next     = PH_SINGLE;
        end
      end
      PH_SINGLE: begin
        emit = 1'b1;
        r    = '{start: 1'b0, data: in_byte, valid: 1'b1,
                 nal_end: in_last, err: ERR_NONE};
      end
      PH_SIZE_HI: begin
        unit_rem_next = {in_byte, 8'd0};
        phase_next    = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        unit_rem_next = {unit_rem[15:8], in_byte};
        phase_next    = ({unit_rem[15:8], in_byte} != 16'd0) ? PH_UNIT_FST : PH_SIZE_HI;
      end
      PH_UNIT_FST, PH_UNIT_MORE: begin
        unit_rem_next = rem_dec;
        emit          = 1'b1;
        r.start       = (phase == PH_UNIT_FST);
        r.data        = in_byte;
        r.valid       = 1'b1;
        r.nal_end     = (rem_dec == 16'd0) || in_last;
        // unit cut short by the packet end
        r.err         = ((rem_dec != 16'd0) && in_last) ? ERR_TRUNC : ERR_NONE;
        phase_next    = (rem_dec == 16'd0) ? PH_SIZE_HI : PH_UNIT_MORE;
      end
      PH_FU_HDR: begin
        fu_end_next = in_byte[6];
        if (in_byte[7]) begin
          // start fragment: rebuilt NAL header behind a start code
          emit           = 1'b1;
          r              = '{start: 1'b1, data: {fu_ind, in_byte[4:0]}, valid: 1'b1,
                             nal_end: in_last && in_byte[6], err: ERR_NONE};
          fu_active_next = !(in_last && in_byte[6]);
          phase_next     = PH_FU_DATA;
        end else if (fu_active) begin
          // end fragment with no payload closes the unit
          if (in_last && in_byte[6]) begin
            emit           = 1'b1;
            r              = '{start: 1'b0, data: 8'd0, valid: 1'b0,
                               nal_end: 1'b1, err: ERR_NONE};
            fu_active_next = 1'b0;
          end
          phase_next = PH_FU_DATA;
        end else begin
          phase_next = PH_DROP;
        end
      end
      PH_FU_DATA: begin
        emit    = 1'b1;
        r       = '{start: 1'b0, data: in_byte, valid: 1'b1,
                    nal_end: in_last && fu_end, err: ERR_NONE};
        if (in_last && fu_end) fu_active_next = 1'b0;
      end
      PH_DROP: begin
      end
      default: begin
      end
    endcase

    // Packet end: flag a packet with no payload, then restart the parse
    if (in_last) begin
      if (phase_next == PH_HDR0 || phase_next == PH_HDR || phase_next == PH_EXT ||
          phase_next == PH_NALHDR) begin
        emit = 1'b1;
        r    = '{start: 1'b0, data: 8'd0, valid: 1'b0, nal_end: 1'b0, err: ERR_SHORT};
      end
      phase_next    = PH_HDR0;
      hdr_left_next = '0;
      ext_cnt_next  = '0;
      ext_flag_next = 1'b0;
      ext_high_next = '0;
      unit_rem_next = '0;
      fu_end_next   = 1'b0;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      hdr_left  <= '0;
      ext_cnt   <= '0;
      ext_flag  <= 1'b0;
      ext_high  <= '0;
      unit_rem  <= '0;
      fu_ind    <= '0;
      fu_active <= 1'b0;
      fu_end    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        hdr_left  <= hdr_left_next;
        ext_cnt   <= ext_cnt_next;
        ext_flag  <= ext_flag_next;
        ext_high  <= ext_high_next;
        unit_rem  <= unit_rem_next;
        fu_ind    <= fu_ind_next;
        fu_active <= fu_active_next;
        fu_end    <= fu_end_next;
      end
      if (accept && emit) begin
        res_valid <= 1'b1;
        res       <= r;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Every packet end brings the parser back to the first header byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_last) |=> (phase == PH_HDR0))
    else $error("parser did not restart after packet end");

  // A short-packet status never carries a start code or a stream byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.err == ERR_SHORT) |-> (!res.start && !res.valid && !res.nal_end))
    else $error("short-packet status mixed with stream data");

endmodule

`default_nettype wire

@@ design/rhd_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhd_serializer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 res_valid,
  input  rhd_pkg::step_res_t  res,
  output logic                res_take,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [15:0]         m_tdata,  // out_byte[7:0], nal_end[8], packet_error[10:9], zeros
  output logic                m_tuser,  // byte_valid
  output logic                m_tlast   // run_last
);
  import rhd_pkg::*;

  logic [2:0] idx;        // result index within the current request
  logic       can_load;
  logic       final_res;
  logic       in_start;   // current result is a start-code byte

  assign can_load  = !m_tvalid || m_tready;
  assign in_start  = res.start && (idx != MAIN_IDX);
  assign final_res = !in_start;
  assign res_take  = res_valid && can_load && final_res;

  // Output register, stepping through the start code before the main result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (can_load) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        if (in_start) begin
          m_tdata <= {5'd0, ERR_NONE, 1'b0, 7'd0, (idx == START_LAST)};
          m_tuser <= 1'b1;
          m_tlast <= 1'b0;
          idx     <= idx + 3'd1;
        end else begin
          m_tdata <= {5'd0, res.err, res.nal_end, res.data};
          m_tuser <= res.valid;
          m_tlast <= 1'b1;
          idx     <= '0;
        end
      end
    end
  end

  // Index only runs past zero while a start code is being sent
  a_idx_start: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0) |-> (res_valid && res.start))
    else $error("result index moved without a start code");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= MAIN_IDX)
    else $error("result index out of range");

  // Short-packet status is always the only result of its byte
  a_status_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10:9] == ERR_SHORT) |-> (m_tlast && !m_tuser))
    else $error("status result not marked as sole result");

endmodule

`default_nettype wire

@@ design/rtp_h264_depacketizer_unit.sv @@
// RTP H.264 depacketizer: RTP packet bytes in, Annex-B byte stream out.
// Input channel s_*: one packet byte per request in s_tdata[7:0], s_tlast on
// the final byte of each packet. RTP header, CSRC list and extension are
// skipped; single NAL units, STAP-A and FU-A payloads become start-code
// delimited NAL units.
// Output channel m_*: one result per request. m_tdata carries the stream byte,
// nal_end and packet_error; m_tuser is byte_valid (0 on a pure status
// result); m_tlast marks the last result caused by one input byte.
// An accepted byte's first result passes the parser register, then the output register.
// Throughput: one input byte per cycle when it causes at most one result and m_tready
// stays high; a byte that opens a NAL unit causes a start code plus its own byte,
// five results, and holds the input while the output register steps through them.
// Reset: parser returns to waiting for the first header byte, no FU-A unit
// open, output empty.
// Stall: while m_tready is low the output register holds, one more request
// waits in the parser register, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module rtp_h264_depacketizer_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte[7:0]
  input  wire         s_tlast,   // packet_last
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], nal_end[8], packet_error[10:9], zeros
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // run_last
);
  import rhd_pkg::*;

  logic      res_valid;
  logic      res_take;
  step_res_t res;

  rhd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  rhd_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ dv/rtp_h264_depacketizer_unit_tb.sv @@
`timescale 1ns / 1ps

module rtp_h264_depacketizer_unit_tb;
  import rhd_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no request on either side
  localparam int LONG_HOLD   = 400;   // receiver hold-off for the fill test
  localparam int TAIL_CYCLES = 16;
  localparam int ITEMS       = 480;   // least number of packet bytes to send in total

  // Parser position inside one RTP packet
  typedef enum logic [3:0] {
    WAIT_V, IN_HDR, IN_EXT, NAL_HDR, SINGLE_BODY, SIZE_HI, SIZE_LO,
    UNIT_FIRST, FU_HDR, FU_BODY, DROPPING, UNIT_REST
  } parse_state_t;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       nal_end;
    logic [1:0] err;
    logic       run_last;
  } stream_res_t;

  // Annex-B stream predictor and the queue of stream results still owed
  class annexb_tracker;
    parse_state_t state;
    int unsigned  hdr_seen, hdr_len;
    bit           ext_pending;
    logic [7:0]   ext_hi;
    logic [15:0]  unit_left;
    logic [2:0]   fu_nri;
    bit           fu_open, fu_closing;
    stream_res_t  step_q[$];
    stream_res_t  expected_stream[$];
    int unsigned  errors;

    function new();
      restart_packet();
      fu_nri  = '0;
      fu_open = 0;
      errors  = 0;
    endfunction

    function void restart_packet();
      state       = WAIT_V;
      hdr_seen    = 0;
      hdr_len     = 12;
      ext_pending = 0;
      ext_hi      = '0;
      unit_left   = '0;
      fu_closing  = 0;
    endfunction

    function void push(logic [7:0] d, bit v, bit e, logic [1:0] er);
      stream_res_t r;
      r.data = d;
      r.valid = v;
      r.nal_end = e;
      r.err = er;
      r.run_last = 0;
      step_q.insert(step_q.size(), r);
    endfunction

    function void push_start_code();
      push(8'h00, 1, 0, ERR_NONE);
      push(8'h00, 1, 0, ERR_NONE);
      push(8'h00, 1, 0, ERR_NONE);
      push(8'h01, 1, 0, ERR_NONE);
    endfunction

    // Note one accepted packet byte and queue the stream results it causes
    function void take_packet_byte(logic [7:0] b, bit is_last);
      int unsigned k, words;
      bit fin;
      logic [1:0] er;
      step_q.delete();
      case (state)
        WAIT_V: begin
          hdr_seen    = 1;
          hdr_len     = 12 + 4 * b[3:0];
          ext_pending = b[4];
          state       = IN_HDR;
        end
        IN_HDR: begin
          hdr_seen++;
          if (hdr_seen >= hdr_len) begin
            if (ext_pending) begin
              hdr_len += 4;
              state = IN_EXT;
            end else begin
              state = NAL_HDR;
            end
          end
        end
        IN_EXT: begin
          hdr_seen++;
          k = hdr_seen - (hdr_len - 4);
          if (k == 3) begin
            ext_hi = b;
          end else if (k >= 4) begin
            words = {ext_hi, b};
            hdr_len += 4 * words;
            ext_pending = 0;
            state = (words != 0) ? IN_HDR : NAL_HDR;
          end
        end
        NAL_HDR: begin
          if (b[4:0] == NAL_STAP_A) begin
            fu_open = 0;
            state = SIZE_HI;
          end else if (b[4:0] == NAL_FU_A) begin
            fu_nri = b[7:5];
            state = FU_HDR;
          end else begin
            fu_open = 0;
            push_start_code();
            push(b, 1, is_last, ERR_NONE);
            state = SINGLE_BODY;
          end
        end
        SINGLE_BODY: push(b, 1, is_last, ERR_NONE);
        SIZE_HI: begin
          unit_left = {b, 8'h00};
          state = SIZE_LO;
        end
        SIZE_LO: begin
          unit_left[7:0] = b;
          state = (unit_left != 0) ? UNIT_FIRST : SIZE_HI;
        end
        UNIT_FIRST, UNIT_REST: begin
          if (state == UNIT_FIRST) push_start_code();
          unit_left = unit_left - 16'd1;
          fin = (unit_left == 0);
          er = ERR_NONE;
          if (!fin && is_last) begin
            fin = 1;
            er = ERR_TRUNC;
          end
          push(b, 1, fin, er);
          state = (unit_left == 0) ? SIZE_HI : UNIT_REST;
        end
        FU_HDR: begin
          fu_closing = b[6];
          if (b[7]) begin
            push_start_code();
            push({fu_nri, b[4:0]}, 1, is_last && b[6], ERR_NONE);
            fu_open = !(is_last && b[6]);
            state = FU_BODY;
          end else if (fu_open) begin
            // end fragment with no payload closes the unit by status only
            if (is_last && b[6]) begin
              push(8'h00, 0, 1, ERR_NONE);
              fu_open = 0;
            end
            state = FU_BODY;
          end else begin
            state = DROPPING;
          end
        end
        FU_BODY: begin
          fin = is_last && fu_closing;
          push(b, 1, fin, ERR_NONE);
          if (fin) fu_open = 0;
        end
        default: ;
      endcase
      if (is_last) begin
        // packet over before any payload byte
        if (state == IN_HDR || state == IN_EXT || state == NAL_HDR)
          push(8'h00, 0, 0, ERR_SHORT);
        restart_packet();
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size() - 1].run_last = 1;
        foreach (step_q[i]) expected_stream.insert(expected_stream.size(), step_q[i]);
      end
    endfunction

    // Compare one accepted stream result with the oldest one owed
    function void check_stream_result(logic [15:0] tdata, logic tuser, logic tlast);
      stream_res_t r;
      logic [15:0] want;
      if (expected_stream.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: expected no result, got tdata=%h tuser=%b tlast=%b",
                   $time, tdata, tuser, tlast);
        return;
      end
      r = expected_stream.pop_front();
      want = {5'b0, r.err, r.nal_end, r.data};
      if (tdata !== want || tuser !== r.valid || tlast !== r.run_last) begin
        errors++;
        if (errors < 50)
          $display("%0t: expected tdata=%h tuser=%b tlast=%b, got tdata=%h tuser=%b tlast=%b",
                   $time, want, r.valid, r.run_last, tdata, tuser, tlast);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  annexb_tracker tracker;
  logic [7:0]    pkt[$];       // packet under construction
  int            pkt_hdr_len;
  int            items_sent = 0;
  int            quiet_cycles = 0;
  bit            calm = 0;      // no idling on either side
  bit            long_hold = 0;
  bit            plain_hdr = 0; // bare 12-byte headers only

  rtp_h264_depacketizer_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Append one byte to the packet under construction
  function automatic void put_byte(input logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endfunction

  // Packet builders
  function automatic void add_header(input int cc, input bit x, input int words);
    put_byte({3'($urandom()), x, 4'(cc)});
    repeat (11 + 4 * cc) put_byte(8'($urandom()));
    if (x) begin
      put_byte(8'($urandom()));
      put_byte(8'($urandom()));
      put_byte(8'(words >> 8));
      put_byte(8'(words));
      repeat (4 * words) put_byte(8'($urandom()));
    end
    pkt_hdr_len = pkt.size();
  endfunction

  function automatic void add_random_header();
    int cc, words;
    bit x;
    if (plain_hdr) begin
      add_header(0, 0, 0);
      return;
    end
    cc = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 15);
    x = ($urandom_range(0, 3) == 0);
    words = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    add_header(cc, x, words);
  endfunction

  function automatic void add_single(input int len);
    logic [4:0] t;
    do t = 5'($urandom()); while (t == NAL_STAP_A || t == NAL_FU_A);
    put_byte({3'($urandom()), t});
    repeat (len - 1) put_byte(8'($urandom()));
  endfunction

  function automatic void add_stap_head();
    put_byte({3'($urandom()), NAL_STAP_A});
  endfunction

  function automatic void add_stap_unit(input int size);
    put_byte(8'(size >> 8));
    put_byte(8'(size));
    repeat (size) put_byte(8'($urandom()));
  endfunction

  function automatic void add_fu(input bit s, input bit e, input int len);
    put_byte({3'($urandom()), NAL_FU_A});
    put_byte({s, e, 1'($urandom()), 5'($urandom())});
    repeat (len) put_byte(8'($urandom()));
  endfunction

  // One packet byte per request; valid held high across back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // keep = 0 sends the whole packet, otherwise only its first keep bytes
  task automatic send_packet(input int keep);
    int n;
    n = (keep > 0 && keep < pkt.size()) ? keep : pkt.size();
    for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
    items_sent += n;
    pkt.delete();
  endtask

  task automatic send_single(input int len);
    add_random_header();
    add_single(len);
    send_packet(0);
  endtask

  task automatic send_fu(input bit s, input bit e, input int len, input bit cut_fu_hdr);
    add_random_header();
    add_fu(s, e, len);
    send_packet(cut_fu_hdr ? pkt_hdr_len + 1 : 0);
  endtask

  // Wait until every owed result is out, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_stream.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic stap_packet();
    int nu, keep;
    add_random_header();
    add_stap_head();
    nu = $urandom_range(0, 3);
    repeat (nu) add_stap_unit(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
    keep = ($urandom_range(0, 3) == 0) ? $urandom_range(pkt_hdr_len + 1, pkt.size()) : 0;
    send_packet(keep);
  endtask

  // Fragmented unit, mostly well formed, sometimes broken on purpose
  task automatic fu_run();
    int nmid, mode, n;
    bit s, e;
    nmid = $urandom_range(0, 3);
    mode = $urandom_range(0, 99);
    n = nmid + 2;
    for (int i = 0; i < n; i++) begin
      s = (i == 0);
      e = (i == n - 1);
      if (mode < 10 && i == 0) s = 0;                      // stray run
      if (mode >= 10 && mode < 20 && i == 1) send_single($urandom_range(1, 4));
      if (mode >= 28 && mode < 35 && i == 1) s = 1;         // restart
      send_fu(s, e, (mode >= 20 && mode < 28 && e) ? 0 : $urandom_range(0, 8),
              mode >= 35 && mode < 41 && i == 1 && !e);
    end
  endtask

  task automatic random_packet();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_random_header();
      send_packet($urandom_range(1, pkt.size()));
    end else if (r < 38) begin
      send_single(($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12));
    end else if (r < 63) begin
      stap_packet();
    end else begin
      fu_run();
    end
  endtask

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end else begin
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Request monitor, result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_packet_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) tracker.check_stream_result(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request for %0d cycles", $time, quiet_cycles);
        $display("rtp_h264_depacketizer_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    plain_hdr = 1;

    // single NAL units: shortest, and one with extreme bytes
    add_header(0, 0, 0);
    add_single(1);
    send_packet(0);
    add_header(15, 0, 0);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    send_packet(0);

    // short packets: inside header, at its end, inside and after extension
    add_header(0, 0, 0);
    send_packet(1);
    add_header(0, 0, 0);
    send_packet(0);
    add_header(2, 1, 1);
    send_packet(12 + 8 + 3);
    add_header(0, 1, 0);
    send_packet(0);
    add_header(1, 1, 2);
    send_packet(0);

    // aggregation: normal with a zero size, empty, truncated, cut in and after size field
    add_header(0, 0, 0);
    add_stap_head();
    add_stap_unit(1);
    add_stap_unit(0);
    add_stap_unit(3);
    send_packet(0);
    add_header(0, 0, 0);
    add_stap_head();
    send_packet(0);
    add_header(1, 0, 0);
    add_stap_head();
    add_stap_unit(258);
    send_packet(pkt_hdr_len + 3 + 4);
    add_header(0, 0, 0);
    add_stap_head();
    add_stap_unit(4);
    send_packet(pkt_hdr_len + 2);
    add_header(0, 0, 0);
    add_stap_head();
    add_stap_unit(4);
    send_packet(pkt_hdr_len + 3);

    // fragmentation: normal run, start and end together, empty end fragment
    send_fu(1, 0, 3, 0);
    send_fu(0, 0, 2, 0);
    send_fu(0, 1, 2, 0);
    send_fu(1, 1, 0, 0);
    send_fu(1, 1, 2, 0);
    send_fu(1, 0, 2, 0);
    send_fu(0, 1, 0, 0);
    // stray fragment, restart, interruption, missing FU header
    send_fu(0, 0, 3, 0);
    send_fu(1, 0, 1, 0);
    send_fu(1, 0, 1, 0);
    send_fu(0, 1, 1, 0);
    send_fu(1, 0, 1, 0);
    send_single(2);
    send_fu(0, 1, 2, 0);
    send_fu(1, 0, 1, 0);
    send_fu(0, 0, 4, 1);
    send_fu(0, 1, 1, 0);

    // long extension with a non-zero high length byte, cut inside its data
    add_header(3, 1, 257);
    send_packet(12 + 12 + 4 + 6);
    settle();

    // fill test: output held while long units keep coming
    long_hold = 1;
    repeat (2) send_single(20);
    settle();
    plain_hdr = 0;

    // random traffic
    for (int k = 0; items_sent < ITEMS || k < 4; k++) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if (k == 2) settle();
      random_packet();
    end
    calm = 0;

    settle();
    if (tracker.errors == 0 && tracker.expected_stream.size() == 0) begin
      $display("rtp_h264_depacketizer_unit: match");
    end else begin
      $display("rtp_h264_depacketizer_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ rtp_h264_depacketizer_unit.f @@
design/rhd_pkg.sv
design/rhd_parser.sv
design/rhd_serializer.sv
design/rtp_h264_depacketizer_unit.sv
dv/rtp_h264_depacketizer_unit_tb.sv
